[hw/rtl/r2fft_pkg.sv]
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types, constants and the twiddle table of the in-place radix-2 FFT.
// ----------------------------------------------------------------------------
package r2fft_pkg;

    localparam int MAX_LOG2 = 10;
    localparam int MAX_POINTS = 1 << MAX_LOG2;
    localparam int ADDR_W = MAX_LOG2;
    localparam int CNT_W = MAX_LOG2 + 1;
    localparam int SAMPLE_W = 16;
    localparam int TW_W = 16;
    localparam int WORD_W = 32;
    localparam int OUT_W = 26;
    localparam int QUARTER = MAX_POINTS / 4;
    localparam int LG_W = 4;

    // Configuration register indexes.
    localparam logic REG_INVERSE = 1'b0;
    localparam logic REG_SIZE = 1'b1;

    // Command codes carried in tuser of the input stream.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Store write data selects.
    localparam logic [2:0] WS_LOAD  = 3'd0;
    localparam logic [2:0] WS_RDATA = 3'd1;
    localparam logic [2:0] WS_AREG  = 3'd2;
    localparam logic [2:0] WS_SUM   = 3'd3;
    localparam logic [2:0] WS_DIFF  = 3'd4;
    localparam logic [2:0] WS_SHIFT = 3'd5;

    // Reciprocals of the Taylor term divisors (2n)(2n+1), scaled by 2^64 and
    // rounded up, so each term division is an exact multiply and shift.
    localparam logic [127:0] RECIP_ONE = 128'd1 << 64;
    localparam logic [127:0] TAYLOR_RECIP [0:11] = '{
        RECIP_ONE / 128'd6   + 128'd1,
        RECIP_ONE / 128'd20  + 128'd1,
        RECIP_ONE / 128'd42  + 128'd1,
        RECIP_ONE / 128'd72  + 128'd1,
        RECIP_ONE / 128'd110 + 128'd1,
        RECIP_ONE / 128'd156 + 128'd1,
        RECIP_ONE / 128'd210 + 128'd1,
        RECIP_ONE / 128'd272 + 128'd1,
        RECIP_ONE / 128'd342 + 128'd1,
        RECIP_ONE / 128'd420 + 128'd1,
        RECIP_ONE / 128'd506 + 128'd1,
        RECIP_ONE / 128'd600 + 128'd1
    };

    typedef logic [TW_W-1:0] rom_t [0:QUARTER];

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [2:0]        wr_sel;
        logic              cap_a;
        logic              tw_en;
        logic [ADDR_W-2:0] tw_idx;
        logic              mul_en;
        logic              rnd_en;
        logic              out_load;
        logic              out_nodata;
        logic              out_last;
        logic [ADDR_W-1:0] out_bin;
        logic              inverse;
        logic [LG_W-1:0]   lg;
    } fft_cmd_t;

    // Quarter-wave sine table, Taylor series in Q30, scaled to Q1.15.
    function automatic rom_t build_rom();
        rom_t              rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        longint unsigned   amp;
        logic [127:0]      prod;
        for (int j = 0; j <= QUARTER; j++)
        begin
            amp  = (64'd1 << (TW_W - 1)) - 64'd1;
            x    = (64'd6746518852 * longint'(j)) >> MAX_LOG2;
            x2   = (x * x) >> 30;
            term = x;
            sum  = 0;
            for (int n = 1; n <= 12; n++)
            begin
                if (n % 2 == 1)
                    sum = sum + longint'(term);
                else
                    sum = sum - longint'(term);
                prod = 128'((term * x2) >> 30) * TAYLOR_RECIP[n-1];
                term = prod[127:64];
            end
            if (sum < 0)
                sum = 0;
            rom[j] = TW_W'((longint'(sum) * amp + (64'd1 << 29)) >> 30);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WORD_W+3:0] v);
        logic signed [WORD_W+3:0] hi;
        logic signed [WORD_W+3:0] lo;
        hi = (WORD_W+4)'({1'b0, {(WORD_W-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi)
            return hi[WORD_W-1:0];
        else if (v < lo)
            return lo[WORD_W-1:0];
        else
            return v[WORD_W-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WORD_W-1:0] v);
        logic signed [WORD_W-1:0] hi;
        logic signed [WORD_W-1:0] lo;
        hi = WORD_W'({1'b0, {(OUT_W-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi)
            return hi[OUT_W-1:0];
        else if (v < lo)
            return lo[OUT_W-1:0];
        else
            return v[OUT_W-1:0];
    endfunction

endpackage

[hw/rtl/r2fft_dp.sv]
// ----------------------------------------------------------------------------
// r2fft_dp
// Sample store, twiddle lookup, butterfly arithmetic and result register.
// ----------------------------------------------------------------------------
module r2fft_dp
(
    input  logic                                    clk,
    input  r2fft_pkg::fft_cmd_t                     cmd,
    input  logic signed [r2fft_pkg::SAMPLE_W-1:0]   real_in,
    input  logic signed [r2fft_pkg::SAMPLE_W-1:0]   imag_in,
    output logic signed [r2fft_pkg::OUT_W-1:0]      real_out,
    output logic signed [r2fft_pkg::OUT_W-1:0]      imag_out,
    output logic [r2fft_pkg::ADDR_W-1:0]            bin_index,
    output logic                                    last_bin,
    output logic                                    no_data
);
    import r2fft_pkg::*;

    localparam int PROD_W = WORD_W + TW_W + 1;
    localparam int T_W = PROD_W + 1 - (TW_W - 1);

    // Word layout: imaginary part in the upper half, real part in the lower.
    logic [2*WORD_W-1:0] mem [0:MAX_POINTS-1];
    logic [2*WORD_W-1:0] rd_data_reg;
    logic [2*WORD_W-1:0] a_reg;
    logic signed [TW_W:0] wr_reg, wi_reg;
    logic signed [TW_W:0] wc_next, ws_next;
    logic signed [PROD_W-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [T_W-1:0] tr_reg, ti_reg;
    logic signed [WORD_W-1:0] br, bi, ar, ai;
    logic signed [PROD_W:0] sr, si;
    logic [2*WORD_W-1:0] wr_data;
    logic [ADDR_W-2:0] j;

    assign br = rd_data_reg[WORD_W-1:0];
    assign bi = rd_data_reg[2*WORD_W-1:WORD_W];
    assign ar = a_reg[WORD_W-1:0];
    assign ai = a_reg[2*WORD_W-1:WORD_W];
    assign j  = cmd.tw_idx;

    always_comb
    begin
        if (j <= (ADDR_W-1)'(QUARTER))
        begin
            wc_next = $signed({1'b0, SINE_ROM[(ADDR_W-1)'(QUARTER) - j]});
            ws_next = $signed({1'b0, SINE_ROM[j]});
        end
        else
        begin
            wc_next = -$signed({1'b0, SINE_ROM[j - (ADDR_W-1)'(QUARTER)]});
            ws_next = $signed({1'b0, SINE_ROM[(ADDR_W-1)'(2*QUARTER) - j]});
        end
    end

    // Products are rounded half up back to Q.15.
    assign sr = (PROD_W+1)'(p1_reg) - (PROD_W+1)'(p2_reg) + (PROD_W+1)'(1 << (TW_W-2));
    assign si = (PROD_W+1)'(p3_reg) + (PROD_W+1)'(p4_reg) + (PROD_W+1)'(1 << (TW_W-2));

    always_comb
    begin
        unique case (cmd.wr_sel)
            WS_LOAD:
                wr_data = {WORD_W'(imag_in), WORD_W'(real_in)};
            WS_RDATA:
                wr_data = rd_data_reg;
            WS_AREG:
                wr_data = a_reg;
            WS_SUM:
                wr_data = {sat_word((WORD_W+4)'(ai) + (WORD_W+4)'(ti_reg)),
                           sat_word((WORD_W+4)'(ar) + (WORD_W+4)'(tr_reg))};
            WS_DIFF:
                wr_data = {sat_word((WORD_W+4)'(ai) - (WORD_W+4)'(ti_reg)),
                           sat_word((WORD_W+4)'(ar) - (WORD_W+4)'(tr_reg))};
            WS_SHIFT:
                wr_data = {WORD_W'(bi >>> cmd.lg), WORD_W'(br >>> cmd.lg)};
            default:
                wr_data = rd_data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[cmd.wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= mem[cmd.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_a)
            a_reg <= rd_data_reg;
        if (cmd.tw_en)
        begin
            wr_reg <= wc_next;
            wi_reg <= cmd.inverse ? ws_next : -ws_next;
        end
        if (cmd.mul_en)
        begin
            p1_reg <= PROD_W'(br) * PROD_W'(wr_reg);
            p2_reg <= PROD_W'(bi) * PROD_W'(wi_reg);
            p3_reg <= PROD_W'(br) * PROD_W'(wi_reg);
            p4_reg <= PROD_W'(bi) * PROD_W'(wr_reg);
        end
        if (cmd.rnd_en)
        begin
            tr_reg <= T_W'(sr >>> (TW_W-1));
            ti_reg <= T_W'(si >>> (TW_W-1));
        end
        if (cmd.out_load)
        begin
            real_out  <= cmd.out_nodata ? '0 : sat_out(br);
            imag_out  <= cmd.out_nodata ? '0 : sat_out(bi);
            bin_index <= cmd.out_nodata ? '0 : cmd.out_bin;
            last_bin  <= cmd.out_nodata ? 1'b0 : cmd.out_last;
            no_data   <= cmd.out_nodata;
        end
    end

endmodule

[hw/rtl/r2fft_ctrl.sv]
// ----------------------------------------------------------------------------
// r2fft_ctrl
// Frame bookkeeping, configuration registers and the transform sequencer.
// ----------------------------------------------------------------------------
module r2fft_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [r2fft_pkg::LG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    input  logic                          in_cmd,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output r2fft_pkg::fft_cmd_t           cmd
);
    import r2fft_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RD_WAIT = 4'd1;
    localparam logic [3:0] S_BR_RD_A = 4'd2;
    localparam logic [3:0] S_BR_RD_B = 4'd3;
    localparam logic [3:0] S_BR_WR_A = 4'd4;
    localparam logic [3:0] S_BR_WR_B = 4'd5;
    localparam logic [3:0] S_BF_RD_A = 4'd6;
    localparam logic [3:0] S_BF_RD_B = 4'd7;
    localparam logic [3:0] S_BF_MUL  = 4'd8;
    localparam logic [3:0] S_BF_RND  = 4'd9;
    localparam logic [3:0] S_BF_WR_A = 4'd10;
    localparam logic [3:0] S_BF_WR_B = 4'd11;
    localparam logic [3:0] S_IV_RD   = 4'd12;
    localparam logic [3:0] S_IV_WR   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [CNT_W-1:0] load_count_reg, load_count_next;
    logic [CNT_W-1:0] read_ptr_reg, read_ptr_next;
    logic frame_ready_reg, frame_ready_next;
    logic inverse_reg;
    logic [LG_W-1:0] size_reg;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [LG_W-1:0] stage_reg, stage_next;
    logic out_valid_reg, out_valid_next;
    logic pend_nodata_reg, pend_nodata_next;
    logic pend_last_reg, pend_last_next;
    logic [ADDR_W-1:0] pend_bin_reg, pend_bin_next;

    logic [LG_W-1:0] lg;
    logic [CNT_W-1:0] n_pts;
    logic [CNT_W-1:0] cnt_inc;
    logic [ADDR_W-1:0] idx_rev, idx_end, half_end, span, bf_i, kk;
    logic accept, bitrev_done;

    function automatic logic [ADDR_W-1:0] bitrev(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] r;
        for (int b = 0; b < ADDR_W; b++)
            r[b] = v[ADDR_W-1-b];
        return r;
    endfunction

    always_comb
    begin
        if (size_reg == '0)
            lg = LG_W'(1);
        else if (size_reg > LG_W'(MAX_LOG2))
            lg = LG_W'(MAX_LOG2);
        else
            lg = size_reg;
    end

    assign n_pts    = CNT_W'(1) << lg;
    assign cnt_inc  = load_count_reg + CNT_W'(1);
    assign idx_rev  = bitrev(idx_reg) >> (LG_W'(MAX_LOG2) - lg);
    assign idx_end  = ADDR_W'(n_pts - CNT_W'(1));
    assign half_end = ADDR_W'((n_pts >> 1) - CNT_W'(1));
    assign span     = ADDR_W'(1) << stage_reg;
    assign kk       = idx_reg & (span - ADDR_W'(1));
    assign bf_i     = ((idx_reg >> stage_reg) << (stage_reg + LG_W'(1))) | kk;
    assign bitrev_done = (idx_reg == idx_end);

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_reg <= 1'b0;
            size_reg    <= LG_W'(MAX_LOG2);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_INVERSE:
                    inverse_reg <= cfg_data[0];
                REG_SIZE:
                    size_reg <= cfg_data;
                default:
                    inverse_reg <= inverse_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        load_count_next  = load_count_reg;
        read_ptr_next    = read_ptr_reg;
        frame_ready_next = frame_ready_reg;
        idx_next         = idx_reg;
        stage_next       = stage_reg;
        pend_nodata_next = pend_nodata_reg;
        pend_last_next   = pend_last_reg;
        pend_bin_next    = pend_bin_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        cmd            = '0;
        cmd.inverse    = inverse_reg;
        cmd.lg         = lg;
        cmd.out_nodata = pend_nodata_reg;
        cmd.out_last   = pend_last_reg;
        cmd.out_bin    = pend_bin_reg;
        cmd.tw_idx     = (ADDR_W-1)'(kk << (LG_W'(MAX_LOG2-1) - stage_reg));

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_cmd == CMD_LOAD)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = load_count_reg[ADDR_W-1:0];
                    cmd.wr_sel  = WS_LOAD;
                    frame_ready_next = 1'b0;
                    read_ptr_next    = '0;
                    if (cnt_inc >= n_pts)
                    begin
                        load_count_next = '0;
                        idx_next        = '0;
                        state_next      = S_BR_RD_A;
                    end
                    else
                        load_count_next = cnt_inc;
                end
                else if (accept)
                begin
                    state_next = S_RD_WAIT;
                    if (frame_ready_reg)
                    begin
                        cmd.rd_en        = 1'b1;
                        cmd.rd_addr      = read_ptr_reg[ADDR_W-1:0];
                        pend_nodata_next = 1'b0;
                        pend_bin_next    = read_ptr_reg[ADDR_W-1:0];
                        pend_last_next   = ((read_ptr_reg + CNT_W'(1)) >= n_pts)
                                           || (read_ptr_reg == '1);
                        if (pend_last_next)
                        begin
                            frame_ready_next = 1'b0;
                            read_ptr_next    = '0;
                        end
                        else
                            read_ptr_next = read_ptr_reg + CNT_W'(1);
                    end
                    else
                        pend_nodata_next = 1'b1;
                end
            end
            S_RD_WAIT:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_BR_RD_A:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = idx_reg;
                if (idx_rev > idx_reg)
                    state_next = S_BR_RD_B;
                else if (bitrev_done)
                begin
                    idx_next   = '0;
                    stage_next = '0;
                    state_next = S_BF_RD_A;
                end
                else
                    idx_next = idx_reg + ADDR_W'(1);
            end
            S_BR_RD_B:
            begin
                cmd.cap_a   = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = idx_rev;
                state_next  = S_BR_WR_A;
            end
            S_BR_WR_A:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = idx_reg;
                cmd.wr_sel  = WS_RDATA;
                state_next  = S_BR_WR_B;
            end
            S_BR_WR_B:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = idx_rev;
                cmd.wr_sel  = WS_AREG;
                if (bitrev_done)
                begin
                    idx_next   = '0;
                    stage_next = '0;
                    state_next = S_BF_RD_A;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = S_BR_RD_A;
                end
            end
            S_BF_RD_A:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = bf_i;
                cmd.tw_en   = 1'b1;
                state_next  = S_BF_RD_B;
            end
            S_BF_RD_B:
            begin
                cmd.cap_a   = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = bf_i + span;
                state_next  = S_BF_MUL;
            end
            S_BF_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_BF_RND;
            end
            S_BF_RND:
            begin
                cmd.rnd_en = 1'b1;
                state_next = S_BF_WR_A;
            end
            S_BF_WR_A:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = bf_i;
                cmd.wr_sel  = WS_SUM;
                state_next  = S_BF_WR_B;
            end
            S_BF_WR_B:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = bf_i + span;
                cmd.wr_sel  = WS_DIFF;
                if (idx_reg != half_end)
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = S_BF_RD_A;
                end
                else if (stage_reg != lg - LG_W'(1))
                begin
                    idx_next   = '0;
                    stage_next = stage_reg + LG_W'(1);
                    state_next = S_BF_RD_A;
                end
                else if (inverse_reg)
                begin
                    idx_next   = '0;
                    state_next = S_IV_RD;
                end
                else
                begin
                    frame_ready_next = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_IV_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = idx_reg;
                state_next  = S_IV_WR;
            end
            S_IV_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = idx_reg;
                cmd.wr_sel  = WS_SHIFT;
                if (bitrev_done)
                begin
                    frame_ready_next = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = S_IV_RD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            load_count_reg  <= '0;
            read_ptr_reg    <= '0;
            frame_ready_reg <= 1'b0;
            idx_reg         <= '0;
            stage_reg       <= '0;
            out_valid_reg   <= 1'b0;
            pend_nodata_reg <= 1'b0;
            pend_last_reg   <= 1'b0;
            pend_bin_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            load_count_reg  <= load_count_next;
            read_ptr_reg    <= read_ptr_next;
            frame_ready_reg <= frame_ready_next;
            idx_reg         <= idx_next;
            stage_reg       <= stage_next;
            out_valid_reg   <= out_valid_next;
            pend_nodata_reg <= pend_nodata_next;
            pend_last_reg   <= pend_last_next;
            pend_bin_reg    <= pend_bin_next;
        end
    end

endmodule

[hw/rtl/radix2_fft_in_place.sv]
// ----------------------------------------------------------------------------
// radix2_fft_in_place
// In-place radix-2 decimation-in-time FFT with a load and read command stream.
// ----------------------------------------------------------------------------
//  Channel  Dir  Contents
//  s_axis   in   tuser: command; tdata: real_in [15:0], imag_in [31:16]
//  m_axis   out  tdata: real_out, imag_out, bin_index; tlast: last_bin;
//                tuser: no_data
//  cfg      in   index 0 inverse_mode, index 1 size_log2
//
// A load beat writes one sample into the store. A read beat reads the store,
// when a frame is ready, and then fills the output register. The load beat that
// completes a frame starts the transform, during which no beat is taken: a
// bit-reversal pass that visits every index and swaps each reversed pair, then
// for each butterfly the steps read A, read B, multiply, round, write A, write B
// (one read and one write port on the store and a four-multiplier butterfly
// unit), then the divide-by-N pass in inverse mode. Reset clears the frame
// counters and the output valid flag; the store itself is not cleared. While a
// result waits on a stalled output, no input beat of either kind is taken.
module radix2_fft_in_place
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [3:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // real_in [15:0], imag_in [31:16]
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // real_out [25:0], imag_out [51:26],
                                        // bin_index [61:52], zero [63:62]
    output logic        m_axis_tlast,   // last_bin
    output logic        m_axis_tuser    // no_data
);
    import r2fft_pkg::*;

    fft_cmd_t cmd;
    logic signed [OUT_W-1:0] real_out, imag_out;
    logic [ADDR_W-1:0] bin_index;

    // The controller owns every counter and the handshake; the datapath only
    // follows its per-cycle commands.
    r2fft_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_cmd    (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    r2fft_dp u_dp
    (
        .clk       (clk),
        .cmd       (cmd),
        .real_in   (s_axis_tdata[15:0]),
        .imag_in   (s_axis_tdata[31:16]),
        .real_out  (real_out),
        .imag_out  (imag_out),
        .bin_index (bin_index),
        .last_bin  (m_axis_tlast),
        .no_data   (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, bin_index, imag_out, real_out};

endmodule

[verif/tb_radix2_fft_in_place.sv]
// ----------------------------------------------------------------------------
// tb_radix2_fft_in_place
// Self-checking bench for the in-place radix-2 FFT: frames of samples are
// loaded, the bins are read back and compared against a bit-exact software
// FFT that runs in step with every accepted input beat.
// ----------------------------------------------------------------------------
module tb_radix2_fft_in_place;
    timeunit 1ns;
    timeprecision 1ps;

    import r2fft_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_addr;
    logic [3:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    radix2_fft_in_place uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // One bin as the block should present it on the output stream.
    typedef struct {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
        logic [ADDR_W-1:0]       bin;
        logic                    last;
        logic                    no_data;
    } bin_t;

    bin_t expected_bins[$];

    // Shadow copy of the block's state, kept in step with accepted beats.
    int signed       re_store[MAX_POINTS];
    int signed       im_store[MAX_POINTS];
    logic [CNT_W-1:0] samples_loaded;
    logic [CNT_W-1:0] bin_ptr;
    logic            frame_done;
    logic            inverse_on;
    logic [LG_W-1:0] size_reg;
    longint          sine_q15[QUARTER+1];

    int errors;
    int beats_sent;
    int frames_run;
    int bins_checked;
    int empty_reads;
    bit no_gaps;

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("radix2_fft_in_place: mismatch");
        $finish;
    end

    // Quarter-wave sine: Taylor series in Q30, then scaled to Q1.15 with
    // round to nearest.
    task automatic make_sine_table();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        for (int j = 0; j <= QUARTER; j++)
        begin
            x    = 64'd6746518852 * j / MAX_POINTS;
            x2   = (x * x) >> 30;
            term = x;
            acc  = 0;
            for (int n = 1; n <= 12; n++)
            begin
                acc  = (n % 2) ? acc + longint'(term) : acc - longint'(term);
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            end
            if (acc < 0)
                acc = 0;
            sine_q15[j] = longint'((unsigned'(acc) * 32767 + (64'd1 << 29)) >> 30);
        end
    endtask

    function automatic int signed clip_word(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic logic signed [OUT_W-1:0] clip_out(int signed v);
        if (v > 33554431)
            return 26'sh1ffffff;
        if (v < -33554432)
            return 26'sh2000000;
        return v[OUT_W-1:0];
    endfunction

    // Out-of-range sizes clamp to 1 .. MAX_LOG2.
    function automatic int active_lg();
        if (size_reg < 1)
            return 1;
        if (size_reg > MAX_LOG2)
            return MAX_LOG2;
        return size_reg;
    endfunction

    task automatic run_fft();
        int     lg;
        int     n;
        int     r;
        int     t;
        int     span;
        int     j;
        longint wr;
        longint ws;
        longint wi;
        longint br;
        longint bi;
        longint tr;
        longint ti;
        longint ar;
        longint ai;
        lg = active_lg();
        n  = 1 << lg;
        // Bit-reversal reorder.
        for (int i = 0; i < n; i++)
        begin
            r = 0;
            for (int b = 0; b < lg; b++)
                r |= ((i >> b) & 1) << (lg - 1 - b);
            if (r > i)
            begin
                t = re_store[i]; re_store[i] = re_store[r]; re_store[r] = t;
                t = im_store[i]; im_store[i] = im_store[r]; im_store[r] = t;
            end
        end
        // Butterfly stages; the twiddle angle index runs over half a turn.
        for (int step = 2; step <= n; step *= 2)
        begin
            span = step / 2;
            for (int k = 0; k < span; k++)
            begin
                j = k * (MAX_POINTS / step);
                if (j <= QUARTER)
                begin
                    wr = sine_q15[QUARTER - j];
                    ws = sine_q15[j];
                end
                else
                begin
                    wr = -sine_q15[j - QUARTER];
                    ws = sine_q15[MAX_POINTS / 2 - j];
                end
                wi = inverse_on ? ws : -ws;
                for (int i = k; i + span < n; i += step)
                begin
                    br = re_store[i + span];
                    bi = im_store[i + span];
                    tr = (br * wr - bi * wi + 16384) >>> 15;
                    ti = (br * wi + bi * wr + 16384) >>> 15;
                    ar = re_store[i];
                    ai = im_store[i];
                    re_store[i]        = clip_word(ar + tr);
                    im_store[i]        = clip_word(ai + ti);
                    re_store[i + span] = clip_word(ar - tr);
                    im_store[i + span] = clip_word(ai - ti);
                end
            end
        end
        // Inverse mode divides by N with a floor shift.
        if (inverse_on)
            for (int i = 0; i < n; i++)
            begin
                re_store[i] = re_store[i] >>> lg;
                im_store[i] = im_store[i] >>> lg;
            end
    endtask

    // Advances the shadow state by one accepted beat and queues the bin
    // that a read produces.
    task automatic predict_beat(logic cmd, logic signed [15:0] re, logic signed [15:0] im);
        int   n;
        int   slot;
        bin_t b;
        n = 1 << active_lg();
        if (cmd == CMD_LOAD)
        begin
            slot = samples_loaded % MAX_POINTS;
            if (frame_done)
            begin
                frame_done = 1'b0;
                bin_ptr    = '0;
            end
            re_store[slot] = int'(re);
            im_store[slot] = int'(im);
            samples_loaded = samples_loaded + 1'b1;
            if (samples_loaded >= n)
            begin
                run_fft();
                samples_loaded = '0;
                bin_ptr        = '0;
                frame_done     = 1'b1;
                frames_run++;
            end
        end
        else if (!frame_done)
        begin
            b = '{re: '0, im: '0, bin: '0, last: 1'b0, no_data: 1'b1};
            expected_bins = {expected_bins, b};
        end
        else
        begin
            slot      = bin_ptr % MAX_POINTS;
            b.re      = clip_out(re_store[slot]);
            b.im      = clip_out(im_store[slot]);
            b.bin     = slot[ADDR_W-1:0];
            b.last    = (bin_ptr + 1 >= n);
            b.no_data = 1'b0;
            expected_bins = {expected_bins, b};
            if (b.last)
            begin
                frame_done = 1'b0;
                bin_ptr    = '0;
            end
            else
                bin_ptr = bin_ptr + 1'b1;
        end
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one beat. Called and returns at a falling edge; valid is only
    // lowered when a gap is actually inserted, so it never toggles twice
    // within one time step.
    task automatic send_beat(logic cmd, logic [15:0] re, logic [15:0] im);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {im, re};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_beat(cmd, re, im);
        beats_sent++;
        @(negedge clk);
    endtask

    // Sample values lean on the extremes of Q1.15.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic load_samples(int count);
        for (int i = 0; i < count; i++)
            send_beat(CMD_LOAD, pick_sample(), pick_sample());
    endtask

    task automatic read_bins(int count);
        for (int i = 0; i < count; i++)
            send_beat(CMD_READ, 16'($urandom()), 16'($urandom()));
    endtask

    // Waits until every queued bin has come out and any transform started by
    // the last load has finished, so a register write lands on an idle block.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_bins.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Holds the write for one cycle, then lowers the enable and waits with it low, so
    // back-to-back writes never assign the enable twice at one edge.
    task automatic write_reg(logic idx, logic [3:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_INVERSE)
            inverse_on = value[0];
        else
            size_reg = value;
        @(negedge clk);
    endtask

    task automatic set_mode(logic inv, logic [3:0] lg);
        wait_idle();
        write_reg(REG_INVERSE, {3'b000, inv});
        write_reg(REG_SIZE, lg);
    endtask

    // Reads straight out of reset find no finished frame.
    task automatic test_empty_reads();
        read_bins(2);
    endtask

    // A full-length frame written with an oversize setting that must clamp to
    // the maximum. It also writes every store entry once, so later reads that
    // wander past N never touch an unwritten word. A partial read is then
    // dropped by the loads of the next test.
    task automatic test_full_frame();
        set_mode(1'b0, 4'd15);
        load_samples(MAX_POINTS);
        read_bins(20);
    endtask

    // Smallest sizes, extreme samples, both directions, reading past the end.
    task automatic test_corners();
        set_mode(1'b0, 4'd1);
        send_beat(CMD_LOAD, 16'h7fff, 16'h8000);
        send_beat(CMD_LOAD, 16'h8000, 16'h7fff);
        read_bins(3);
        set_mode(1'b1, 4'd0);
        send_beat(CMD_LOAD, 16'h8000, 16'h8000);
        send_beat(CMD_LOAD, 16'h7fff, 16'h7fff);
        read_bins(2);
        set_mode(1'b1, 4'd2);
        load_samples(4);
        read_bins(4);
    endtask

    // Size moved under a half-loaded frame, then moved after a transform.
    task automatic test_size_changes();
        set_mode(1'b0, 4'd3);
        load_samples(3);
        set_mode(1'b0, 4'd1);
        load_samples(1);
        read_bins(2);
        set_mode(1'b0, 4'd2);
        load_samples(4);
        set_mode(1'b0, 4'd3);
        read_bins(8);
        set_mode(1'b0, 4'd3);
        load_samples(8);
        set_mode(1'b0, 4'd1);
        read_bins(2);
    endtask

    // Mostly whole frames of small sizes read back in full, mixed with
    // partial reads, stray reads, half-loaded frames and resizes.
    task automatic test_random_frames();
        int lg;
        int n;
        while (beats_sent < 1650)
        begin
            lg = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(5, 8);
            if ($urandom_range(0, 29) == 0)
                lg = $urandom_range(11, 15);
            if ($urandom_range(0, 29) == 0)
                lg = 0;
            set_mode(1'($urandom_range(0, 1)), lg[3:0]);
            no_gaps = ($urandom_range(0, 3) == 0);
            n = 1 << ((lg < 1) ? 1 : (lg > MAX_LOG2 ? MAX_LOG2 : lg));
            if (n > 256)
                n = 4;
            case ($urandom_range(0, 9))
                0: read_bins($urandom_range(1, 2));
                1: load_samples($urandom_range(1, n));
                default:
                begin
                    if (1 << active_lg() == n)
                    begin
                        load_samples(n);
                        read_bins(($urandom_range(0, 4) == 0) ? $urandom_range(0, n + 2) : n);
                    end
                    else
                        read_bins(1);
                end
            endcase
            no_gaps = 1'b0;
        end
    endtask

    // Output back-pressure: runs of ready, short stalls, and rare long ones.
    initial
    begin
        int run;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (run == 0)
            begin
                case ($urandom_range(0, 9))
                    0:       begin m_axis_tready <= 1'b0; run = $urandom_range(15, 50); end
                    1, 2, 3: begin m_axis_tready <= 1'b0; run = $urandom_range(1, 3); end
                    default: begin m_axis_tready <= 1'b1; run = $urandom_range(1, 30); end
                endcase
            end
            else
                run--;
        end
    end

    // Compares each output beat with the oldest queued bin.
    always @(posedge clk)
    begin
        bin_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_bins.size() == 0)
            begin
                $error("output beat with no bin pending");
                errors++;
            end
            else
            begin
                want = expected_bins.pop_front();
                bins_checked++;
                if (want.no_data)
                    empty_reads++;
                if (m_axis_tdata[25:0] !== want.re)
                begin
                    $error("real_out: expected %0d, got %0d", want.re,
                           $signed(m_axis_tdata[25:0]));
                    errors++;
                end
                if (m_axis_tdata[51:26] !== want.im)
                begin
                    $error("imag_out: expected %0d, got %0d", want.im,
                           $signed(m_axis_tdata[51:26]));
                    errors++;
                end
                if (m_axis_tdata[61:52] !== want.bin)
                begin
                    $error("bin_index: expected %0d, got %0d", want.bin, m_axis_tdata[61:52]);
                    errors++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last_bin: expected %0b, got %0b", want.last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tuser !== want.no_data)
                begin
                    $error("no_data: expected %0b, got %0b", want.no_data, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_INVERSE;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD;
        errors        = 0;
        beats_sent    = 0;
        frames_run    = 0;
        bins_checked  = 0;
        empty_reads   = 0;
        no_gaps       = 1'b0;
        samples_loaded = '0;
        bin_ptr       = '0;
        frame_done    = 1'b0;
        inverse_on    = 1'b0;
        size_reg      = 4'd10;
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            re_store[i] = 0;
            im_store[i] = 0;
        end
        make_sine_table();
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_reads();
        test_full_frame();
        test_corners();
        test_size_changes();
        test_random_frames();

        s_axis_tvalid <= 1'b0;
        while (expected_bins.size() != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);

        $display("Sent %0d beats through %0d transforms, forward and inverse, sizes 2 to 1024.",
                 beats_sent, frames_run);
        $display("Checked %0d output beats, %0d of them reads with no frame ready.",
                 bins_checked, empty_reads);
        if (errors == 0)
            $display("radix2_fft_in_place: match");
        else
            $display("radix2_fft_in_place: mismatch");
        $finish;
    end

endmodule
